// ===== sv/restoring_divider_64_by_32_core_macros.svh =====
// Assertion macros for the 64-by-32 restoring divider.
// Depends on nothing; included by files that check their own logic.
`ifndef RESTORING_DIVIDER_64_BY_32_CORE_MACROS_SVH
`define RESTORING_DIVIDER_64_BY_32_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted.
`define RDIV64_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("rdiv64 assertion failed");
// Clocked check that also holds during reset.
`define RDIV64_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("rdiv64 assertion failed");
`else
`define RDIV64_ASSERT(label, clk, rst_n, prop)
`define RDIV64_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== sv/rdiv64_pkg.sv =====
// Types and constants shared by the 64-by-32 restoring divider.
// Depends on nothing.
package rdiv64_pkg;

    localparam int unsigned NumBits = 64;
    localparam int unsigned DenBits = 32;

    typedef struct packed {
        logic [NumBits-1:0] dividend;
        logic [DenBits-1:0] divisor;
    } t_div_in;

    typedef struct packed {
        logic [NumBits-1:0] quotient;
        logic [DenBits-1:0] remainder;
        logic               divide_by_zero;
    } t_div_out;

    // One pipeline slot: partial remainder, dividend bits still to come with
    // quotient bits shifted in at the bottom, and the divisor.
    typedef struct packed {
        logic [DenBits-1:0] part;
        logic [NumBits-1:0] numquo;
        logic [DenBits-1:0] divisor;
    } t_stage;

endpackage

// ===== sv/restoring_divider_64_by_32_core.sv =====
// Unsigned 64-by-32 restoring divider, one quotient bit per pipeline stage.
// Each item runs through the 64 step stages and then the result register to
// o_done. Throughput: one item every cycle; busy stays low, and the result
// strobe cannot be held off by the receiver.
// Reset (synchronous, active low) drops every item in flight; data holds.
// Depends on rdiv64_pkg, rdiv64_stage and the assertion macro header.
`include "restoring_divider_64_by_32_core_macros.svh"

module restoring_divider_64_by_32_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rdiv64_pkg::t_div_in  i_item,
    output logic                 o_done,
    output rdiv64_pkg::t_div_out o_result
);

    localparam int unsigned Steps = rdiv64_pkg::NumBits;

    // Valid bit and payload at the input of every step; index Steps is the tail.
    logic                 w_valid [Steps+1];
    rdiv64_pkg::t_stage   w_stage [Steps+1];

    logic                 w_accept;
    logic                 w_zero_den;
    logic                 r_done;
    rdiv64_pkg::t_div_out r_result;
    rdiv64_pkg::t_div_out n_result;

    // The pipeline never stalls, so an item is taken whenever start is high.
    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    // Load the head slot: empty partial remainder, dividend MSB first.
    assign w_valid[0]         = w_accept;
    assign w_stage[0].part    = '0;
    assign w_stage[0].numquo  = i_item.dividend;
    assign w_stage[0].divisor = i_item.divisor;

    // Advance one quotient bit per stage; after the last step numquo holds
    // the full quotient and part the remainder.
    for (genvar g = 0; g < Steps; g++) begin : g_step
        rdiv64_stage u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_stage (w_stage[g]),
            .o_valid (w_valid[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    // A zero divisor makes every step subtract nothing and take the bit;
    // replace that garbage with zeros and raise the flag.
    always_comb begin
        w_zero_den = (w_stage[Steps].divisor == '0);
        if (w_zero_den) begin
            n_result.quotient  = '0;
            n_result.remainder = '0;
        end else begin
            n_result.quotient  = w_stage[Steps].numquo;
            n_result.remainder = w_stage[Steps].part;
        end
        n_result.divide_by_zero = w_zero_den;
    end

    // Register the strobe and the result side by side, so the result is shown for exactly one cycle, with the strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_valid[Steps];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // A strobe only ever comes from an accepted item that has run the whole pipeline.
    `RDIV64_ASSERT(a_done_follows_start, i_clk, i_rst_n, o_done |-> $past(w_accept, 65))
    // A division by zero reports all-zero quotient and remainder.
    `RDIV64_ASSERT(a_dbz_zero, i_clk, i_rst_n,
        (o_done && o_result.divide_by_zero) |->
        (o_result.quotient == '0 && o_result.remainder == '0))
    // Out of the last step the remainder is below a nonzero divisor.
    `RDIV64_ASSERT(a_rem_below_den, i_clk, i_rst_n,
        (w_valid[Steps] && !w_zero_den) |->
        (w_stage[Steps].part < w_stage[Steps].divisor))
    // The block never refuses an item.
    `RDIV64_ASSERT_ALWAYS(a_never_busy, i_clk, !busy)

endmodule

// ===== sv/rdiv64_stage.sv =====
// One restoring shift-and-subtract step of the divider, registered.
// Depends on rdiv64_pkg.
module rdiv64_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  rdiv64_pkg::t_stage i_stage,
    output logic               o_valid,
    output rdiv64_pkg::t_stage o_stage
);

    logic                            w_carry;
    logic [rdiv64_pkg::DenBits-1:0]  w_shifted;
    logic [rdiv64_pkg::DenBits+1:0]  w_diff;
    logic                            w_take;
    logic                            r_valid;
    rdiv64_pkg::t_stage              r_stage;
    rdiv64_pkg::t_stage              n_stage;

    always_comb begin
        w_carry   = i_stage.part[rdiv64_pkg::DenBits-1];
        w_shifted = {i_stage.part[rdiv64_pkg::DenBits-2:0],
                     i_stage.numquo[rdiv64_pkg::NumBits-1]};
        // 34-bit difference: top bit is the borrow of the 33-bit compare
        w_diff    = {1'b0, w_carry, w_shifted} - {2'b00, i_stage.divisor};
        w_take    = ~w_diff[rdiv64_pkg::DenBits+1];
        n_stage.part    = w_take ? w_diff[rdiv64_pkg::DenBits-1:0] : w_shifted;
        n_stage.numquo  = {i_stage.numquo[rdiv64_pkg::NumBits-2:0], w_take};
        n_stage.divisor = i_stage.divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ===== tb/restoring_divider_64_by_32_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the pipelined 64-by-32 unsigned restoring divider.
// Depends on rdiv64_pkg and restoring_divider_64_by_32_core; stands alone otherwise.

module restoring_divider_64_by_32_core_tb;

    // Hold a bit-serial model of the divider and the results it still owes.
    class division_scoreboard;
        rdiv64_pkg::t_div_out owed_results[$];
        int unsigned n_items;
        int unsigned n_zero_divisor;
        int unsigned n_checked;
        int unsigned n_errors;

        // Shift one dividend bit in per step, most significant first; the
        // 33-bit compare covers the carry out of the partial remainder.
        function automatic rdiv64_pkg::t_div_out divide_bits(rdiv64_pkg::t_div_in it);
            logic [32:0]          shifted;
            logic [31:0]          part;
            rdiv64_pkg::t_div_out res;
            res = '0;
            part = '0;
            if (it.divisor == '0) begin
                res.divide_by_zero = 1'b1;
                return res;
            end
            for (int b = rdiv64_pkg::NumBits - 1; b >= 0; b--) begin
                shifted = {part, it.dividend[b]};
                if (shifted >= {1'b0, it.divisor}) begin
                    shifted = shifted - {1'b0, it.divisor};
                    res.quotient[b] = 1'b1;
                end
                part = shifted[31:0];
            end
            res.remainder = part;
            return res;
        endfunction

        function void note_item(rdiv64_pkg::t_div_in it);
            n_items++;
            if (it.divisor == '0) n_zero_divisor++;
            owed_results.push_back(divide_bits(it));
        endfunction

        task report_mismatch(string what);
            n_errors++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        task check_result(rdiv64_pkg::t_div_out got);
            rdiv64_pkg::t_div_out want;
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result q=%h r=%h z=%b",
                                          got.quotient, got.remainder, got.divide_by_zero));
                return;
            end
            want = owed_results.pop_front();
            n_checked++;
            if (got.quotient !== want.quotient)
                report_mismatch($sformatf("quotient %h, want %h", got.quotient, want.quotient));
            if (got.remainder !== want.remainder)
                report_mismatch($sformatf("remainder %h, want %h",
                                          got.remainder, want.remainder));
            if (got.divide_by_zero !== want.divide_by_zero)
                report_mismatch($sformatf("divide_by_zero %b, want %b",
                                          got.divide_by_zero, want.divide_by_zero));
        endtask
    endclass

    localparam int unsigned PipeLatency = 65;   // accepting edge to o_done cycle
    localparam int unsigned RandomItems = 1530;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    rdiv64_pkg::t_div_in  i_item;
    logic                 o_done;
    rdiv64_pkg::t_div_out o_result;

    division_scoreboard scoreboard = new();

    restoring_divider_64_by_32_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // 4 ns clock period.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Check every result on the edge that ends its strobe cycle; the values
    // seen here are the ones from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            scoreboard.check_result(o_result);
    end

    // Present one item and hold it until the block takes it. Start stays
    // high on return so back-to-back items need no extra assignment.
    task automatic send_item(input rdiv64_pkg::t_div_in it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        scoreboard.note_item(it);
    endtask

    // Maybe drop start for a while: often no gap (never in a burst), else mostly short gaps, now and then a long one.
    task automatic idle_sender(input bit burst);
        int unsigned roll;
        int unsigned gap;
        roll = $urandom_range(0, 99);
        if (burst || roll < 55) gap = 0;
        else if (roll < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 60);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Build one item and send it, then maybe idle.
    task automatic send_pair(input logic [63:0] num, input logic [31:0] den,
                             input bit burst);
        rdiv64_pkg::t_div_in it;
        it.dividend = num;
        it.divisor  = den;
        send_item(it);
        idle_sender(burst);
    endtask

    // Pick a divisor: zero now and then, small ones, ones with the top bit set (these drive the carry path),
    // odd values of random width, values near all ones, and full-width random values.
    function automatic logic [31:0] pick_divisor();
        int unsigned kind;
        kind = $urandom_range(0, 19);
        case (kind)
            0:       return '0;
            1, 2:    return $urandom_range(1, 16);
            3, 4, 5: return 32'h8000_0000 | $urandom;
            6, 7:    return ($urandom >> $urandom_range(0, 31)) | 32'h1;
            8:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // Pick a dividend: mostly full 64-bit random values, some narrowed so
    // that quotients are small or zero, and now and then all ones.
    function automatic logic [63:0] pick_dividend();
        int unsigned kind;
        logic [63:0] num;
        num  = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        case (kind)
            0:       return num >> $urandom_range(0, 63);
            1:       return {32'h0, num[31:0]};
            2:       return 64'hFFFF_FFFF_FFFF_FFFF;
            default: return num;
        endcase
    endfunction

    initial begin
        int unsigned wait_cycles;
        bit          burst;
        start   <= 1'b0;
        i_item  <= '0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items: field extremes, zero divisor, equal operands,
        // dividend below divisor, and divisors with the top bit set where
        // the shifted remainder carries out of 32 bits.
        send_pair(64'h0, 32'h1, 1'b0);
        send_pair(64'h0, 32'h0, 1'b0);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 32'h1, 1'b0);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b1);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0001, 1'b1);
        send_pair(64'hFFFF_FFFF_FFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
        send_pair(64'h0000_0000_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_pair(64'h0000_0000_FFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
        send_pair(64'h0000_0000_0000_0007, 32'h0000_0008, 1'b0);
        send_pair(64'h8000_0000_0000_0000, 32'h2, 1'b0);
        send_pair(64'h8000_0000_0000_0000, 32'hC000_0000, 1'b1);
        send_pair(64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_pair(64'h1234_5678_9ABC_DEF0, 32'h0, 1'b1);
        send_pair(64'h0000_0001_0000_0000, 32'h1_0000, 1'b0);
        send_pair(64'hFFFF_FFFE_0000_0001, 32'hFFFF_FFFF, 1'b0);
        send_pair(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0);
        send_pair(64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_pair(64'h1, 32'hFFFF_FFFF, 1'b0);

        // Random items, alternating stretches of back-to-back traffic with
        // stretches of random gaps.
        for (int n = 0; n < RandomItems; n++) begin
            burst = ((n / 150) % 3) == 1;
            send_pair(pick_dividend(), pick_divisor(), burst);
        end
        start <= 1'b0;

        // Drain: wait for every owed result, then let the pipe run empty.
        wait_cycles = 0;
        while (scoreboard.owed_results.size() != 0 && wait_cycles < 4 * PipeLatency) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (scoreboard.owed_results.size() != 0)
            scoreboard.report_mismatch($sformatf("%0d results never arrived",
                                                 scoreboard.owed_results.size()));
        repeat (PipeLatency + 5) @(posedge i_clk);

        $display("Sent %0d divisions (%0d by zero), checked %0d results, %0d mismatches.",
                 scoreboard.n_items, scoreboard.n_zero_divisor,
                 scoreboard.n_checked, scoreboard.n_errors);
        if (scoreboard.n_errors == 0)
            $display("restoring_divider_64_by_32_core_tb: done, clean");
        else
            $display("restoring_divider_64_by_32_core_tb: done, errors");
        $finish;
    end

    // Watchdog: a correct run needs well under a millisecond.
    initial begin
        #4_000_000;
        $display("Timed out with %0d results still owed.", scoreboard.owed_results.size());
        $display("restoring_divider_64_by_32_core_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/rdiv64_pkg.sv
sv/rdiv64_stage.sv
sv/restoring_divider_64_by_32_core.sv
tb/restoring_divider_64_by_32_core_tb.sv
